FILE: rtl/core/vector3_arithmetic_unit_defines.svh
// Assertion macros for the vector unit checker.
`ifndef VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
`define VECTOR3_ARITHMETIC_UNIT_DEFINES_SVH
// Implication check, reset-qualified.
`define V3AU_ASSERT_IMP(label, ck, rn, a, c, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) else $error(msg);
// Next-cycle implication check.
`define V3AU_ASSERT_NXT(label, ck, rn, a, c, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) else $error(msg);
`endif

FILE: rtl/core/v3au_pkg.sv
// Shared types, constants and opcodes for the vector unit.
package v3au_pkg;
    localparam int CompWidth = 16;
    localparam int FracBits = 8;
    localparam int ScalarWidth = 33;
    localparam int SqWidth = 34;
    localparam int RootWidth = 17;
    localparam int RootSteps = 17;
    localparam int QuotWidth = 25;
    localparam int DivSteps = 25;
    localparam int DivDenWidth = 17;
    localparam int DivRemWidth = 18;

    typedef enum logic [2:0] {
        FUNC_ADD   = 3'd0,
        FUNC_SUB   = 3'd1,
        FUNC_SCALE = 3'd2,
        FUNC_DOT   = 3'd3,
        FUNC_CROSS = 3'd4,
        FUNC_MAG   = 3'd5,
        FUNC_NORM  = 3'd6,
        FUNC_NONE  = 3'd7
    } func_t;

    typedef logic signed [CompWidth-1:0] comp_t;

    typedef struct packed {
        func_t func;
        comp_t ax;
        comp_t ay;
        comp_t az;
        comp_t rx;
        comp_t ry;
        comp_t rz;
        logic signed [ScalarWidth-1:0] scalar;
        logic sat;
    } item_t;

    function automatic comp_t sat_comp(input logic signed [47:0] v, output logic flag);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        hi = 48'sd32767;
        lo = -48'sd32768;
        flag = 1'b0;
        if (v > hi)
        begin
            flag = 1'b1;
            sat_comp = comp_t'(hi);
        end
        else if (v < lo)
        begin
            flag = 1'b1;
            sat_comp = comp_t'(lo);
        end
        else
        begin
            sat_comp = v[CompWidth-1:0];
        end
    endfunction
endpackage

FILE: rtl/core/v3au_sqrt_cell.sv
// One restoring square-root step on a pipeline of items.
module v3au_sqrt_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  v3au_pkg::item_t in_item,
    input  logic [v3au_pkg::SqWidth-1:0] in_rem,
    input  logic [v3au_pkg::SqWidth-1:0] in_sq,
    input  logic [v3au_pkg::RootWidth-1:0] in_root,
    output logic out_valid,
    output v3au_pkg::item_t out_item,
    output logic [v3au_pkg::SqWidth-1:0] out_rem,
    output logic [v3au_pkg::SqWidth-1:0] out_sq,
    output logic [v3au_pkg::RootWidth-1:0] out_root
);
    import v3au_pkg::*;
    logic valid_reg;
    item_t item_reg;
    logic [SqWidth-1:0] rem_reg, rem_next, sq_reg, trial;
    logic [RootWidth-1:0] root_reg, root_next;
    logic [SqWidth+1:0] rem_sh;

    always_comb
    begin
        rem_sh = {in_rem, in_sq[SqWidth-1 -: 2]};
        trial = SqWidth'({in_root, 2'b01});
        if (rem_sh >= {2'b00, trial})
        begin
            rem_next = SqWidth'(rem_sh - {2'b00, trial});
            root_next = {in_root[RootWidth-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[SqWidth-1:0];
            root_next = {in_root[RootWidth-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            rem_reg <= rem_next;
            sq_reg <= {in_sq[SqWidth-3:0], 2'b00};
            root_reg <= root_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;
    assign out_rem = rem_reg;
    assign out_sq = sq_reg;
    assign out_root = root_reg;
endmodule

FILE: rtl/core/v3au_div_cell.sv
// One restoring division step for the three normalize quotients.
module v3au_div_cell (
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  v3au_pkg::item_t in_item,
    input  logic [v3au_pkg::DivDenWidth-1:0] in_den,
    input  logic [2:0][v3au_pkg::DivRemWidth-1:0] in_rem,
    input  logic [2:0][v3au_pkg::QuotWidth-1:0] in_num,
    output logic out_valid,
    output v3au_pkg::item_t out_item,
    output logic [v3au_pkg::DivDenWidth-1:0] out_den,
    output logic [2:0][v3au_pkg::DivRemWidth-1:0] out_rem,
    output logic [2:0][v3au_pkg::QuotWidth-1:0] out_num
);
    import v3au_pkg::*;
    logic valid_reg;
    item_t item_reg;
    logic [DivDenWidth-1:0] den_reg;
    logic [2:0][DivRemWidth-1:0] rem_reg, rem_next;
    logic [2:0][QuotWidth-1:0] num_reg, num_next;
    logic [DivRemWidth-1:0] sh;

    always_comb
    begin
        sh = '0;
        for (int i = 0; i < 3; i++)
        begin
            sh = {in_rem[i][DivRemWidth-2:0], in_num[i][QuotWidth-1]};
            if (sh >= {1'b0, in_den})
            begin
                rem_next[i] = sh - {1'b0, in_den};
                num_next[i] = {in_num[i][QuotWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = sh;
                num_next[i] = {in_num[i][QuotWidth-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= in_item;
            den_reg <= in_den;
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item = item_reg;
    assign out_den = den_reg;
    assign out_rem = rem_reg;
    assign out_num = num_reg;
endmodule

FILE: rtl/core/vector3_arithmetic_unit.sv
// Top level of the three-component fixed-point vector unit.
// Usage:
//   s_axis carries one item per transfer: func in tuser, the seven Q7.8
//   operands in tdata. m_axis returns one result per item: rx, ry, rz,
//   scalar_out in tdata and saturated in tuser.
//   Items can enter every cycle while s_axis_tready is high; nothing depends on an earlier item.
//   Every opcode takes the same path: product and sum stages, the chain of
//   square-root cells (one root bit per cell), the chain of division cells
//   (one quotient bit per cell) used by normalize, and the output register.
//   Throughput is one item per cycle while m_axis_tready is high.
//   The whole chain advances in lockstep; an output register with a skid
//   entry takes the last result, so one stalled result does not stop the
//   chain; s_axis_tready follows the chain enable combinationally.
//   When the receiver stalls, the chain holds once the skid entry is full.
//   Reset clears all valid bits; no result is pending after reset.
module vector3_arithmetic_unit (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // ax, ay, az, bx, by_comp, bz, scale_factor
    input  logic [111:0] s_axis_tdata,
    // func
    input  logic [2:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // rx, ry, rz, scalar_out, zero fill
    output logic [87:0] m_axis_tdata,
    // saturated
    output logic m_axis_tuser
);
    import v3au_pkg::*;

    // Chain enable: advance while output slot is free or draining, or the skid entry is free.
    logic en;
    logic out_valid_reg, skid_valid_reg;
    item_t out_item_reg, skid_item_reg;
    logic ready_reg;

    // Stage 0: products.
    logic v0_reg;
    func_t f0_reg;
    comp_t ax0_reg, ay0_reg, az0_reg, bx0_reg, by0_reg, bz0_reg;
    logic signed [31:0] p_reg [0:8];
    comp_t in_a [0:2];
    comp_t in_b [0:2];
    comp_t in_s;

    assign in_a[0] = s_axis_tdata[15:0];
    assign in_a[1] = s_axis_tdata[31:16];
    assign in_a[2] = s_axis_tdata[47:32];
    assign in_b[0] = s_axis_tdata[63:48];
    assign in_b[1] = s_axis_tdata[79:64];
    assign in_b[2] = s_axis_tdata[95:80];
    assign in_s = s_axis_tdata[111:96];

    logic take;
    assign take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f0_reg <= func_t'(s_axis_tuser);
            ax0_reg <= in_a[0];
            ay0_reg <= in_a[1];
            az0_reg <= in_a[2];
            bx0_reg <= in_b[0];
            by0_reg <= in_b[1];
            bz0_reg <= in_b[2];
            case (func_t'(s_axis_tuser))
                FUNC_SCALE:
                begin
                    p_reg[0] <= in_s * in_a[0];
                    p_reg[1] <= in_s * in_a[1];
                    p_reg[2] <= in_s * in_a[2];
                    p_reg[3] <= '0;
                    p_reg[4] <= '0;
                    p_reg[5] <= '0;
                end
                FUNC_CROSS:
                begin
                    p_reg[0] <= in_a[1] * in_b[2];
                    p_reg[1] <= in_a[2] * in_b[0];
                    p_reg[2] <= in_a[0] * in_b[1];
                    p_reg[3] <= in_a[2] * in_b[1];
                    p_reg[4] <= in_a[0] * in_b[2];
                    p_reg[5] <= in_a[1] * in_b[0];
                end
                FUNC_DOT:
                begin
                    p_reg[0] <= in_a[0] * in_b[0];
                    p_reg[1] <= in_a[1] * in_b[1];
                    p_reg[2] <= in_a[2] * in_b[2];
                    p_reg[3] <= '0;
                    p_reg[4] <= '0;
                    p_reg[5] <= '0;
                end
                default:
                begin
                    p_reg[0] <= in_a[0] * in_a[0];
                    p_reg[1] <= in_a[1] * in_a[1];
                    p_reg[2] <= in_a[2] * in_a[2];
                    p_reg[3] <= '0;
                    p_reg[4] <= '0;
                    p_reg[5] <= '0;
                end
            endcase
            p_reg[6] <= '0;
            p_reg[7] <= '0;
            p_reg[8] <= '0;
        end
    end

    // Stage 1: sums, shifts, saturation.
    logic v1_reg;
    item_t i1_reg, i1_next;
    logic [SqWidth-1:0] sq1_reg, sq1_next;
    logic signed [47:0] t0, t1, t2;
    logic fl0, fl1, fl2;
    comp_t c0, c1, c2;
    logic signed [SqWidth:0] dsum;

    always_comb
    begin
        i1_next = '0;
        i1_next.func = f0_reg;
        i1_next.ax = ax0_reg;
        i1_next.ay = ay0_reg;
        i1_next.az = az0_reg;
        sq1_next = '0;
        t0 = '0;
        t1 = '0;
        t2 = '0;
        dsum = SqWidth'(0) + p_reg[0] + p_reg[1] + p_reg[2] + p_reg[6] + p_reg[7] + p_reg[8];
        case (f0_reg)
            FUNC_ADD:
            begin
                t0 = 48'(ax0_reg) + 48'(bx0_reg);
                t1 = 48'(ay0_reg) + 48'(by0_reg);
                t2 = 48'(az0_reg) + 48'(bz0_reg);
            end
            FUNC_SUB:
            begin
                t0 = 48'(ax0_reg) - 48'(bx0_reg);
                t1 = 48'(ay0_reg) - 48'(by0_reg);
                t2 = 48'(az0_reg) - 48'(bz0_reg);
            end
            FUNC_SCALE:
            begin
                t0 = 48'(p_reg[0]) >>> FracBits;
                t1 = 48'(p_reg[1]) >>> FracBits;
                t2 = 48'(p_reg[2]) >>> FracBits;
            end
            FUNC_CROSS:
            begin
                t0 = (48'(p_reg[0]) - 48'(p_reg[3])) >>> FracBits;
                t1 = (48'(p_reg[1]) - 48'(p_reg[4])) >>> FracBits;
                t2 = (48'(p_reg[2]) - 48'(p_reg[5])) >>> FracBits;
            end
            default:
            begin
                t0 = '0;
                t1 = '0;
                t2 = '0;
            end
        endcase
        c0 = sat_comp(t0, fl0);
        c1 = sat_comp(t1, fl1);
        c2 = sat_comp(t2, fl2);
        case (f0_reg)
            FUNC_ADD, FUNC_SUB, FUNC_SCALE, FUNC_CROSS:
            begin
                i1_next.rx = c0;
                i1_next.ry = c1;
                i1_next.rz = c2;
                i1_next.sat = fl0 | fl1 | fl2;
            end
            FUNC_DOT:
                i1_next.scalar = dsum[ScalarWidth-1:0];
            FUNC_MAG, FUNC_NORM:
                sq1_next = dsum[SqWidth-1:0];
            default:
                i1_next.sat = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg <= i1_next;
            sq1_reg <= sq1_next;
        end
    end

    // Square-root chain.
    logic sv [0:RootSteps];
    item_t si [0:RootSteps];
    logic [SqWidth-1:0] srem [0:RootSteps];
    logic [SqWidth-1:0] ssq [0:RootSteps];
    logic [RootWidth-1:0] sroot [0:RootSteps];

    assign sv[0] = v1_reg;
    assign si[0] = i1_reg;
    assign srem[0] = '0;
    assign ssq[0] = sq1_reg;
    assign sroot[0] = '0;

    for (genvar g = 0; g < RootSteps; g++)
    begin : g_sqrt
        v3au_sqrt_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(sv[g]), .in_item(si[g]), .in_rem(srem[g]),
            .in_sq(ssq[g]), .in_root(sroot[g]),
            .out_valid(sv[g+1]), .out_item(si[g+1]), .out_rem(srem[g+1]),
            .out_sq(ssq[g+1]), .out_root(sroot[g+1])
        );
    end

    // Prepare division: magnitude of |a| << FracBits over root; set the magnitude result.
    logic dv_reg;
    item_t di_reg, di_next;
    logic [DivDenWidth-1:0] dden_reg;
    logic [2:0][QuotWidth-1:0] dnum_reg, dnum_next;
    logic [2:0] dneg_reg;
    comp_t root_a [0:2];

    always_comb
    begin
        di_next = si[RootSteps];
        root_a[0] = si[RootSteps].ax;
        root_a[1] = si[RootSteps].ay;
        root_a[2] = si[RootSteps].az;
        for (int i = 0; i < 3; i++)
        begin
            logic [CompWidth-1:0] mag;
            mag = root_a[i][CompWidth-1] ? CompWidth'(-root_a[i]) : root_a[i];
            dnum_next[i] = {QuotWidth'(mag)} << FracBits;
        end
        if (si[RootSteps].func == FUNC_MAG)
            di_next.scalar = ScalarWidth'(sroot[RootSteps]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= 1'b0;
        else if (en)
            dv_reg <= sv[RootSteps];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            di_reg <= di_next;
            dden_reg <= sroot[RootSteps];
            dnum_reg <= dnum_next;
            dneg_reg <= {root_a[2][CompWidth-1], root_a[1][CompWidth-1], root_a[0][CompWidth-1]};
        end
    end

    // Division chain.
    logic qv [0:DivSteps];
    item_t qi [0:DivSteps];
    logic [DivDenWidth-1:0] qden [0:DivSteps];
    logic [2:0][DivRemWidth-1:0] qrem [0:DivSteps];
    logic [2:0][QuotWidth-1:0] qnum [0:DivSteps];
    logic [2:0] qneg [0:DivSteps];

    assign qv[0] = dv_reg;
    assign qi[0] = di_reg;
    assign qden[0] = dden_reg;
    assign qrem[0] = '0;
    assign qnum[0] = dnum_reg;
    assign qneg[0] = dneg_reg;

    for (genvar g = 0; g < DivSteps; g++)
    begin : g_div
        logic [2:0] neg_reg;
        v3au_div_cell u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(qv[g]), .in_item(qi[g]), .in_den(qden[g]),
            .in_rem(qrem[g]), .in_num(qnum[g]),
            .out_valid(qv[g+1]), .out_item(qi[g+1]), .out_den(qden[g+1]),
            .out_rem(qrem[g+1]), .out_num(qnum[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (en)
                neg_reg <= qneg[g];
        end
        assign qneg[g+1] = neg_reg;
    end

    // Final: sign, saturate, pick normalize result.
    item_t fin_next;
    logic signed [47:0] nq [0:2];
    comp_t nc [0:2];
    logic nf [0:2];

    always_comb
    begin
        fin_next = qi[DivSteps];
        for (int i = 0; i < 3; i++)
        begin
            nq[i] = qneg[DivSteps][i] ? -48'(qnum[DivSteps][i]) : 48'(qnum[DivSteps][i]);
            nc[i] = sat_comp(nq[i], nf[i]);
        end
        if (qi[DivSteps].func == FUNC_NORM)
        begin
            if (qden[DivSteps] == '0)
            begin
                fin_next.rx = qi[DivSteps].ax;
                fin_next.ry = qi[DivSteps].ay;
                fin_next.rz = qi[DivSteps].az;
                fin_next.sat = 1'b0;
            end
            else
            begin
                fin_next.rx = nc[0];
                fin_next.ry = nc[1];
                fin_next.rz = nc[2];
                fin_next.sat = nf[0] | nf[1] | nf[2];
            end
        end
    end

    // Output register with skid entry.
    logic last_v;
    assign last_v = qv[DivSteps];
    assign en = !out_valid_reg || m_axis_tready || !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_axis_tready)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                    skid_valid_reg <= en && last_v;
                end
                else
                begin
                    out_valid_reg <= en && last_v;
                end
            end
            else if (en && last_v)
            begin
                skid_valid_reg <= 1'b1;
            end
            ready_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_item_reg <= skid_item_reg;
                skid_item_reg <= fin_next;
            end
            else
            begin
                out_item_reg <= fin_next;
            end
        end
        else if (en && last_v)
        begin
            skid_item_reg <= fin_next;
        end
    end

    assign s_axis_tready = ready_reg && en;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, out_item_reg.scalar, out_item_reg.rz,
                           out_item_reg.ry, out_item_reg.rx};
    assign m_axis_tuser = out_item_reg.sat;
endmodule

FILE: rtl/core/v3au_checker.sv
// Port-level checker for the vector unit, bound to the top level.
`include "vector3_arithmetic_unit_defines.svh"
module v3au_checker (
    input logic clk,
    input logic rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic m_axis_tuser
);
    `V3AU_ASSERT_NXT(a_hold_valid, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `V3AU_ASSERT_NXT(a_hold_data, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
    `V3AU_ASSERT_IMP(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[87:81] == 7'd0, "tdata fill not zero")
    `V3AU_ASSERT_IMP(a_scalar_flag, clk, rst_n, m_axis_tvalid && m_axis_tdata[80:48] != 33'd0, !m_axis_tuser && m_axis_tdata[47:0] == 48'd0, "scalar result with vector part")
endmodule

bind vector3_arithmetic_unit v3au_checker u_v3au_checker (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

FILE: test/testbench.sv
// Self-checking testbench for the three-component fixed-point vector unit.
module testbench;
    import v3au_pkg::*;

    localparam int Latency = 46;
    localparam int WatchdogLimit = 20000;

    typedef struct {
        logic [15:0] rx;
        logic [15:0] ry;
        logic [15:0] rz;
        logic [32:0] scalar_out;
        logic saturated;
    } vec_result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic m_axis_tuser;

    vec_result_t expected_results[$];
    int errors = 0;
    int idle_cycles = 0;
    int hold_off = 0;
    bit random_stall = 0;

    vector3_arithmetic_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic longint clip16(input longint v, inout bit flag);
        if (v > 32767)
        begin
            flag = 1;
            return 32767;
        end
        if (v < -32768)
        begin
            flag = 1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint floor_root(input longint n);
        longint r;
        r = 0;
        for (int b = 17; b >= 0; b--)
        begin
            if ((r + (longint'(1) << b)) * (r + (longint'(1) << b)) <= n)
                r = r + (longint'(1) << b);
        end
        return r;
    endfunction

    function automatic vec_result_t vector_math(input func_t f, input longint a[3],
                                                input longint b[3], input longint s);
        vec_result_t res;
        longint r[3];
        longint scalar;
        longint den;
        bit flag;
        r = '{0, 0, 0};
        scalar = 0;
        flag = 0;
        case (f)
            FUNC_ADD:
                for (int i = 0; i < 3; i++) r[i] = clip16(a[i] + b[i], flag);
            FUNC_SUB:
                for (int i = 0; i < 3; i++) r[i] = clip16(a[i] - b[i], flag);
            FUNC_SCALE:
                for (int i = 0; i < 3; i++) r[i] = clip16((s * a[i]) >>> 8, flag);
            FUNC_DOT:
                scalar = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
            FUNC_CROSS:
            begin
                r[0] = clip16((a[1] * b[2] - a[2] * b[1]) >>> 8, flag);
                r[1] = clip16((a[2] * b[0] - a[0] * b[2]) >>> 8, flag);
                r[2] = clip16((a[0] * b[1] - a[1] * b[0]) >>> 8, flag);
            end
            FUNC_MAG, FUNC_NORM:
            begin
                den = floor_root(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
                if (f == FUNC_MAG)
                    scalar = den;
                else if (den == 0)
                    r = a;
                else
                    for (int i = 0; i < 3; i++) r[i] = clip16((a[i] * 256) / den, flag);
            end
            default:
                ;
        endcase
        res.rx = r[0][15:0];
        res.ry = r[1][15:0];
        res.rz = r[2][15:0];
        res.scalar_out = scalar[32:0];
        res.saturated = flag;
        return res;
    endfunction

    task automatic send_item(input func_t f, input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input logic [15:0] bx,
                             input logic [15:0] by_comp, input logic [15:0] bz,
                             input logic [15:0] sf, input bit with_gap);
        longint a[3];
        longint b[3];
        int gap;
        gap = 0;
        if (with_gap && $urandom_range(0, 2) == 0)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a = '{longint'($signed(ax)), longint'($signed(ay)), longint'($signed(az))};
        b = '{longint'($signed(bx)), longint'($signed(by_comp)), longint'($signed(bz))};
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= f;
        s_axis_tdata <= {sf, bz, by_comp, bx, az, ay, ax};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(vector_math(f, a, b, longint'($signed(sf))));
        @(negedge clk);
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        idle_sender();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [15:0] random_comp();
        case ($urandom_range(0, 5))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(input bit with_gap);
        send_item(func_t'($urandom_range(0, 7)), random_comp(), random_comp(), random_comp(),
                  random_comp(), random_comp(), random_comp(), random_comp(), with_gap);
    endtask

    task automatic test_directed();
        send_item(FUNC_ADD, 16'h7fff, 16'h8000, 16'h0100, 16'h0001, 16'hffff, 16'h0100,
                  16'h0, 0);
        send_item(FUNC_SUB, 16'h8000, 16'h7fff, 16'h0, 16'h0001, 16'hffff, 16'h0, 16'h0, 0);
        send_item(FUNC_SCALE, 16'h7fff, 16'h8000, 16'hff80, 16'h0, 16'h0, 16'h0, 16'h8000, 0);
        send_item(FUNC_SCALE, 16'h0100, 16'hffff, 16'h0003, 16'h0, 16'h0, 16'h0, 16'h0180, 0);
        send_item(FUNC_DOT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                  16'h0, 0);
        send_item(FUNC_DOT, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h0, 0);
        send_item(FUNC_CROSS, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                  16'h0, 0);
        send_item(FUNC_CROSS, 16'h0100, 16'h0, 16'h0, 16'h0, 16'h0100, 16'h0, 16'h0, 0);
        send_item(FUNC_MAG, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_MAG, 16'h0300, 16'h0400, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NORM, 16'h0, 16'h0, 16'h0, 16'h1234, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NORM, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NORM, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NORM, 16'h8000, 16'h7fff, 16'h0001, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NORM, 16'h0300, 16'hfc00, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0);
        send_item(FUNC_NONE, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                  16'hffff, 0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        random_stall = 1;
        repeat (300) send_random(1);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        random_stall = 0;
        hold_off = 150;
        repeat (100) send_random(0);
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end
        else if (random_stall && $urandom_range(0, 3) == 0)
            m_axis_tready <= ($urandom_range(0, 9) == 0) ? 1'b1 : 1'b0;
        else
            m_axis_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        vec_result_t want;
        vec_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.rx = m_axis_tdata[15:0];
            got.ry = m_axis_tdata[31:16];
            got.rz = m_axis_tdata[47:32];
            got.scalar_out = m_axis_tdata[80:48];
            got.saturated = m_axis_tuser;
            if (expected_results.size() == 0)
            begin
                $display("%0t unexpected transfer rx=%h ry=%h rz=%h scalar=%h sat=%b", $time,
                         got.rx, got.ry, got.rz, got.scalar_out, got.saturated);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.rx !== want.rx || got.ry !== want.ry || got.rz !== want.rz
                    || got.scalar_out !== want.scalar_out || got.saturated !== want.saturated)
                begin
                    $display("%0t expected rx=%h ry=%h rz=%h scalar=%h sat=%b", $time,
                             want.rx, want.ry, want.rz, want.scalar_out, want.saturated);
                    $display("%0t actual   rx=%h ry=%h rz=%h scalar=%h sat=%b", $time,
                             got.rx, got.ry, got.rz, got.scalar_out, got.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FUNC_ADD;
        m_axis_tready = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_random_traffic();
        test_back_pressure();
        repeat (Latency + 10) @(negedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
